// ===== design/ata_taskfile_command_issuer_assert.svh =====
// ----------------------------------------------------------------------------
// ata_taskfile_command_issuer_assert.svh
// assertion macros shared by the checker of the task-file command issuer
// ----------------------------------------------------------------------------
`ifndef ATA_TASKFILE_COMMAND_ISSUER_ASSERT_SVH
`define ATA_TASKFILE_COMMAND_ISSUER_ASSERT_SVH

// checked outside reset
`define ATI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define ATI_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/ati_pkg.sv =====
// ----------------------------------------------------------------------------
// ati_pkg
// types and constants of the ata task-file command issuer
// ----------------------------------------------------------------------------
`default_nettype none

package ati_pkg;

  typedef struct packed {
    logic        action;
    logic [1:0]  drive_index;
    logic [31:0] block_address;
    logic [7:0]  sector_count;
  } in_item_t;

  typedef struct packed {
    logic       bus_channel;
    logic [3:0] reg_index;
    logic [7:0] reg_value;
    logic       last;
  } out_item_t;

  // classified request handed from front to back
  typedef struct packed {
    logic       chan;
    logic       wide;
    logic [7:0] select;
    logic [7:0] count;
    logic [7:0] lba0;
    logic [7:0] lba1;
    logic [7:0] lba2;
    logic [7:0] lba3;
    logic [7:0] command;
  } desc_t;

  // register write sequence of the back end
  typedef enum logic [4:0] {
    ST_CTRL,
    ST_SELECT,
    ST_HOB_A,
    ST_COUNT1,
    ST_LOB_A,
    ST_HOB_B,
    ST_LBA3,
    ST_LOB_B,
    ST_HOB_C,
    ST_LBA4,
    ST_LOB_C,
    ST_HOB_D,
    ST_LBA5,
    ST_LOB_D,
    ST_COUNT0,
    ST_LBA0,
    ST_LBA1,
    ST_LBA2,
    ST_COMMAND
  } step_t;

  localparam logic [1:0] CFG_CHANNEL_MAP = 2'd0;
  localparam logic [1:0] CFG_SLAVE_MAP   = 2'd1;
  localparam logic [1:0] CFG_LBA_MAP     = 2'd2;

  localparam logic [3:0] REG_COUNT0  = 4'd2;
  localparam logic [3:0] REG_LBA0    = 4'd3;
  localparam logic [3:0] REG_LBA1    = 4'd4;
  localparam logic [3:0] REG_LBA2    = 4'd5;
  localparam logic [3:0] REG_SELECT  = 4'd6;
  localparam logic [3:0] REG_COMMAND = 4'd7;
  localparam logic [3:0] REG_COUNT1  = 4'd8;
  localparam logic [3:0] REG_LBA3    = 4'd9;
  localparam logic [3:0] REG_LBA4    = 4'd10;
  localparam logic [3:0] REG_LBA5    = 4'd11;
  localparam logic [3:0] REG_CONTROL = 4'd12;

  localparam logic [7:0] CTRL_NIEN = 8'h02;
  localparam logic [7:0] CTRL_HOB  = 8'h80;

  localparam logic [7:0] SEL_LBA = 8'hE0;
  localparam logic [7:0] SEL_CHS = 8'hA0;

  localparam logic [7:0] CMD_READ       = 8'h20;
  localparam logic [7:0] CMD_WRITE      = 8'h30;
  localparam logic [7:0] CMD_READ_EXT   = 8'h24;
  localparam logic [7:0] CMD_WRITE_EXT  = 8'h34;

  localparam logic [31:0] LBA48_START = 32'h1000_0000;

  // floor(x / 63) = (x * CHS_RECIP) >> CHS_SHIFT for every 28-bit x
  localparam logic [28:0] CHS_RECIP = 29'd272696337;
  localparam int unsigned CHS_SHIFT = 34;

endpackage

`default_nettype wire

// ===== design/ata_taskfile_command_issuer.sv =====
// ----------------------------------------------------------------------------
// ata_taskfile_command_issuer
// turns a sector request into the ordered ata task-file register writes
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Each request yields
// 19 register writes in lba48 mode and 7 in lba28 or chs mode, one write per
// clock on out_item, flagged by out_valid for one cycle; the command write
// carries last. The back end issues one write per cycle, and the front end
// takes one request per cycle while busy is low, classifying it through the
// front stage into a queue of QUEUE_DEPTH entries; busy rises only when that
// queue and the front stage hold QUEUE_DEPTH requests. With the queue empty,
// a request passes the front stage register and the queue before its first
// write is registered onto the ports. The receiver cannot stall: every write
// must be taken in the cycle it is shown.
// ----------------------------------------------------------------------------
`default_nettype none

module ata_taskfile_command_issuer
  import ati_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire in_item_t   in_item,
  output logic            out_valid,
  output out_item_t       out_item,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [3:0] cfg_data
);

  localparam int unsigned LVL_W = $clog2(QUEUE_DEPTH + 1);

  logic             push;
  desc_t            push_desc;
  logic             pop;
  desc_t            head_desc;
  logic             empty;
  logic [LVL_W-1:0] q_level;

  ati_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_level   (q_level),
    .busy      (busy),
    .push      (push),
    .push_desc (push_desc)
  );

  ati_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head_desc (head_desc),
    .empty     (empty),
    .level     (q_level)
  );

  ati_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (empty),
    .head_desc (head_desc),
    .pop       (pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

// ===== design/ati_front.sv =====
// ----------------------------------------------------------------------------
// ati_front
// accepts requests, holds the drive maps and classifies each request into
// lba48, lba28 or chs register bytes behind its s1 register
// ----------------------------------------------------------------------------
`default_nettype none

module ati_front
  import ati_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire in_item_t                         in_item,
  input  wire logic                             cfg_we,
  input  wire logic [1:0]                       cfg_index,
  input  wire logic [3:0]                       cfg_data,
  input  wire logic [$clog2(DEPTH+1)-1:0]       q_level,
  output logic                                  busy,
  output logic                                  push,
  output desc_t                                 push_desc
);

  localparam int unsigned LVL_W = $clog2(DEPTH + 1);
  localparam int unsigned QUOT_W = 23;

  logic [3:0] chan_map_r;
  logic [3:0] slave_map_r;
  logic [3:0] lba_map_r;

  logic              s1_valid_r;
  in_item_t          s1_item_r;
  logic              s1_chan_r;
  logic              s1_slave_r;
  logic              s1_lba_r;
  logic [QUOT_W-1:0] s1_quot_r;

  logic              accept;
  logic [56:0]       prod;
  logic [LVL_W:0]    pending;

  logic              wide;
  logic [5:0]        rem;
  logic [7:0]        sect;
  logic [3:0]        head;
  logic [15:0]       cyl;
  logic [7:0]        slave_bit;

  assign pending = {1'b0, q_level} + (LVL_W + 1)'(s1_valid_r);
  assign busy    = pending >= (LVL_W + 1)'(DEPTH);
  assign accept  = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_map_r  <= '0;
      slave_map_r <= '0;
      lba_map_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CHANNEL_MAP: chan_map_r  <= cfg_data;
        CFG_SLAVE_MAP:   slave_map_r <= cfg_data;
        CFG_LBA_MAP:     lba_map_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // divide by 63 through the reciprocal
  assign prod = 57'(in_item.block_address[27:0]) * 57'(CHS_RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r  <= in_item;
      s1_chan_r  <= chan_map_r[in_item.drive_index];
      s1_slave_r <= slave_map_r[in_item.drive_index];
      s1_lba_r   <= lba_map_r[in_item.drive_index];
      s1_quot_r  <= prod[56:CHS_SHIFT];
    end
  end

  // remainder: addr = 63q + r, so r = addr + q mod 64
  assign wide      = s1_item_r.block_address >= LBA48_START;
  assign rem       = s1_item_r.block_address[5:0] + s1_quot_r[5:0];
  assign sect      = {2'b00, rem} + 8'd1;
  assign head      = s1_quot_r[3:0];
  assign cyl       = s1_quot_r[19:4];
  assign slave_bit = {3'b000, s1_slave_r, 4'b0000};

  always_comb begin
    push_desc       = '0;
    push_desc.chan  = s1_chan_r;
    push_desc.wide  = wide;
    push_desc.count = s1_item_r.sector_count;
    push_desc.lba3  = s1_item_r.block_address[31:24];
    if (wide) begin
      push_desc.select  = SEL_LBA | slave_bit;
      push_desc.lba0    = s1_item_r.block_address[7:0];
      push_desc.lba1    = s1_item_r.block_address[15:8];
      push_desc.lba2    = s1_item_r.block_address[23:16];
      push_desc.command = s1_item_r.action ? CMD_WRITE_EXT : CMD_READ_EXT;
    end else if (s1_lba_r) begin
      push_desc.select  = SEL_LBA | slave_bit | {4'b0000, s1_item_r.block_address[27:24]};
      push_desc.lba0    = s1_item_r.block_address[7:0];
      push_desc.lba1    = s1_item_r.block_address[15:8];
      push_desc.lba2    = s1_item_r.block_address[23:16];
      push_desc.command = s1_item_r.action ? CMD_WRITE : CMD_READ;
    end else begin
      push_desc.select  = SEL_CHS | slave_bit | {4'b0000, head};
      push_desc.lba0    = sect;
      push_desc.lba1    = cyl[7:0];
      push_desc.lba2    = cyl[15:8];
      push_desc.command = s1_item_r.action ? CMD_WRITE : CMD_READ;
    end
  end

  assign push = s1_valid_r;

endmodule

`default_nettype wire

// ===== design/ati_queue.sv =====
// ----------------------------------------------------------------------------
// ati_queue
// small queue of classified requests between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module ati_queue
  import ati_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        push,
  input  wire desc_t                       push_desc,
  input  wire logic                        pop,
  output desc_t                            head_desc,
  output logic                             empty,
  output logic [$clog2(DEPTH+1)-1:0]       level
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned LVL_W = $clog2(DEPTH + 1);

  desc_t            mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [LVL_W-1:0] level_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [LVL_W-1:0] level_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    level_nxt = level_r + LVL_W'(push) - LVL_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

  assign head_desc = mem_r[rd_ptr_r];
  assign empty     = level_r == '0;
  assign level     = level_r;

endmodule

`default_nettype wire

// ===== design/ati_back.sv =====
// ----------------------------------------------------------------------------
// ati_back
// walks the register write sequence of the head request, one write a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module ati_back
  import ati_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  empty,
  input  wire desc_t head_desc,
  output logic       pop,
  output logic       out_valid,
  output out_item_t  out_item
);

  step_t      step_r;
  step_t      step_nxt;
  logic       out_valid_r;
  out_item_t  out_item_r;
  out_item_t  item;
  logic       emit;

  assign emit = !empty;

  always_comb begin
    item             = '0;
    item.bus_channel = head_desc.chan;
    item.reg_index   = REG_CONTROL;
    item.reg_value   = CTRL_NIEN;
    case (step_r)
      ST_CTRL, ST_LOB_A, ST_LOB_B, ST_LOB_C, ST_LOB_D: begin
        item.reg_index = REG_CONTROL;
        item.reg_value = CTRL_NIEN;
      end
      ST_HOB_A, ST_HOB_B, ST_HOB_C, ST_HOB_D: begin
        item.reg_index = REG_CONTROL;
        item.reg_value = CTRL_HOB | CTRL_NIEN;
      end
      ST_SELECT: begin
        item.reg_index = REG_SELECT;
        item.reg_value = head_desc.select;
      end
      ST_COUNT1: begin
        item.reg_index = REG_COUNT1;
        item.reg_value = '0;
      end
      ST_LBA3: begin
        item.reg_index = REG_LBA3;
        item.reg_value = head_desc.lba3;
      end
      ST_LBA4: begin
        item.reg_index = REG_LBA4;
        item.reg_value = '0;
      end
      ST_LBA5: begin
        item.reg_index = REG_LBA5;
        item.reg_value = '0;
      end
      ST_COUNT0: begin
        item.reg_index = REG_COUNT0;
        item.reg_value = head_desc.count;
      end
      ST_LBA0: begin
        item.reg_index = REG_LBA0;
        item.reg_value = head_desc.lba0;
      end
      ST_LBA1: begin
        item.reg_index = REG_LBA1;
        item.reg_value = head_desc.lba1;
      end
      ST_LBA2: begin
        item.reg_index = REG_LBA2;
        item.reg_value = head_desc.lba2;
      end
      ST_COMMAND: begin
        item.reg_index = REG_COMMAND;
        item.reg_value = head_desc.command;
        item.last      = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    step_nxt = step_r;
    if (emit) begin
      if (step_r == ST_COMMAND) begin
        step_nxt = ST_CTRL;
      end else if (step_r == ST_SELECT && !head_desc.wide) begin
        step_nxt = ST_COUNT0;
      end else begin
        step_nxt = step_t'(step_r + 5'd1);
      end
    end
  end

  assign pop = emit && (step_r == ST_COMMAND);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= ST_CTRL;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item_r <= item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

// ===== design/ati_checker.sv =====
// ----------------------------------------------------------------------------
// ati_checker
// port-level checks of the task-file command issuer, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "ata_taskfile_command_issuer_assert.svh"

module ati_checker
  import ati_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire out_item_t  out_item
);

  `ATI_ASSERT_ALWAYS(a_quiet_after_reset, !rst_n |=> !out_valid,
                     "write shown right after reset")

  `ATI_ASSERT(a_last_is_command,
              out_valid && out_item.last |-> out_item.reg_index == REG_COMMAND,
              "last not on command write")

  `ATI_ASSERT(a_select_after_ctrl,
              out_valid && out_item.reg_index == REG_SELECT |-> $past(out_valid) &&
              $past(out_item.reg_index) == REG_CONTROL && !$past(out_item.last),
              "select not preceded by control")

  `ATI_ASSERT(a_ctrl_value,
              out_valid && out_item.reg_index == REG_CONTROL |->
              out_item.reg_value == CTRL_NIEN || out_item.reg_value == (CTRL_HOB | CTRL_NIEN),
              "bad control byte")

  `ATI_ASSERT(a_channel_steady,
              out_valid && $past(out_valid) && !$past(out_item.last) |->
              out_item.bus_channel == $past(out_item.bus_channel),
              "channel changed inside a run")

endmodule

bind ata_taskfile_command_issuer ati_checker u_ati_checker (.*);

`default_nettype wire
